>>> hdl/assert_macros.svh
// assertion helpers, empty when synthesizing
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_ANY(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_CLK(label, prop)
`define ASSERT_ANY(label, prop)
`endif

`endif

>>> hdl/imu_mag_pkg.sv
`default_nettype none
package imu_mag_pkg;

  localparam int AXIS_W = 16;
  localparam int MAG_W = 20;
  localparam int WEIGHT_W = 11;
  localparam int WEIGHT_FRAC = 10;
  localparam int MUL_W = MAG_W + 1;
  localparam int T_W = 32;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1024);
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(614);
  localparam logic [T_W-1:0] ROUND_HALF = T_W'(512);
  localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_MUL,
    ST_UPDATE,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

>>> hdl/imu_magnitude_ema_filter.sv
`default_nettype none
// Takes one six-axis sample word and returns the accelerometer and gyro vector
// magnitudes (sqrt of the sum of squares, FRAC_BITS fraction bits, rounded
// down, saturated to 20 bits) together with their updated moving averages,
// avg += round(new_weight * (mag - avg) / 1024); weights above 1024 act as
// 1024. Only the low SAMPLE_BITS bits of each axis are used, as a signed value.
// One multiplier squares the axes and forms the average products, and one
// restoring square root unit yields one result bit per cycle, so a sample is
// accepted only in the idle state, after the previous sample's result has
// been loaded into the output register.
// The result sits in an output register; the next sample may be taken while
// it waits. new_weight may be written at any time the block is idle.
module imu_magnitude_ema_filter #(
  parameter int FRAC_BITS = 4,
  parameter int SAMPLE_BITS = 16
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [imu_mag_pkg::WEIGHT_W-1:0]     new_weight,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire  signed [imu_mag_pkg::AXIS_W-1:0] acc_x,
  input  wire  signed [imu_mag_pkg::AXIS_W-1:0] acc_y,
  input  wire  signed [imu_mag_pkg::AXIS_W-1:0] acc_z,
  input  wire  signed [imu_mag_pkg::AXIS_W-1:0] rate_x,
  input  wire  signed [imu_mag_pkg::AXIS_W-1:0] rate_y,
  input  wire  signed [imu_mag_pkg::AXIS_W-1:0] rate_z,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic [imu_mag_pkg::MAG_W-1:0]        acc_magnitude,
  output logic [imu_mag_pkg::MAG_W-1:0]        rate_magnitude,
  output logic [imu_mag_pkg::MAG_W-1:0]        acc_smoothed,
  output logic [imu_mag_pkg::MAG_W-1:0]        rate_smoothed
);
  import imu_mag_pkg::*;

  localparam int SQ_W = 2 * SAMPLE_BITS;
  localparam int RAD_W = SQ_W + 2 * FRAC_BITS;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W = ROOT_W + 2;
  localparam int CNT_W = $clog2(ROOT_W + 1);
  localparam int PROD_W = 2 * MUL_W;

  state_t state, state_next;

  logic [WEIGHT_W-1:0] weight;
  logic [CNT_W-1:0] cnt;
  logic vec;

  logic [AXIS_W-1:0] acc_x_q, acc_y_q, acc_z_q, rate_x_q, rate_y_q, rate_z_q;
  logic [SQ_W-1:0] sum;
  logic signed [PROD_W-1:0] prod;
  logic [RAD_W-1:0] rad;
  logic [REM_W-1:0] rem;
  logic [ROOT_W-1:0] root;
  logic [MAG_W-1:0] acc_mag, rate_mag;
  logic [MAG_W-1:0] acc_average, rate_average;

  logic in_fire, load_out;
  logic sq_last, root_last;

  // shared multiplier
  logic [AXIS_W-1:0] raw_sel;
  logic signed [MUL_W-1:0] sample_sel;
  logic [WEIGHT_W-1:0] weight_eff;
  logic [MAG_W-1:0] mag_sel, avg_sel;
  logic signed [MUL_W-1:0] diff;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_out;

  // square root step
  logic [REM_W-1:0] rem_sh, trial;
  logic root_bit;
  logic [ROOT_W-1:0] root_next;
  logic [ROOT_W+MAG_W-1:0] root_ext;
  logic [MAG_W-1:0] root_sat;

  // average update
  logic signed [T_W-1:0] t_sum, q_step, avg_next;
  logic [MAG_W-1:0] avg_clamped;

  assign in_fire = in_valid && in_ready;
  assign sq_last = (cnt == CNT_W'(3));
  assign root_last = (cnt == CNT_W'(ROOT_W - 1));
  assign cfg_ready = 1'b1;

  always_comb begin
    case (cnt[1:0])
      2'd0: raw_sel = vec ? rate_x_q : acc_x_q;
      2'd1: raw_sel = vec ? rate_y_q : acc_y_q;
      default: raw_sel = vec ? rate_z_q : acc_z_q;
    endcase
  end

  assign sample_sel = MUL_W'(signed'(raw_sel[SAMPLE_BITS-1:0]));
  assign weight_eff = (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;
  assign mag_sel = vec ? rate_mag : acc_mag;
  assign avg_sel = vec ? rate_average : acc_average;
  assign diff = signed'({1'b0, mag_sel}) - signed'({1'b0, avg_sel});
  assign mul_a = (state == ST_MUL) ? diff : sample_sel;
  assign mul_b = (state == ST_MUL) ? MUL_W'(signed'({1'b0, weight_eff})) : sample_sel;
  assign mul_out = mul_a * mul_b;

  assign rem_sh = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
  assign trial = {root, 2'b01};
  assign root_bit = (rem_sh >= trial);
  assign root_next = {root[ROOT_W-2:0], root_bit};
  assign root_ext = {{MAG_W{1'b0}}, root_next};
  assign root_sat = (|root_ext[ROOT_W+MAG_W-1:MAG_W]) ? MAG_MAX : root_ext[MAG_W-1:0];

  assign t_sum = signed'(prod[T_W-1:0]) + signed'(ROUND_HALF);
  assign q_step = t_sum >>> WEIGHT_FRAC;
  assign avg_next = T_W'(signed'({1'b0, avg_sel})) + q_step;

  always_comb begin
    if (avg_next[T_W-1]) begin
      avg_clamped = '0;
    end else if (|avg_next[T_W-2:MAG_W]) begin
      avg_clamped = MAG_MAX;
    end else begin
      avg_clamped = avg_next[MAG_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SQUARE;
      end
      ST_SQUARE: begin
        if (sq_last) state_next = ST_ROOT;
      end
      ST_ROOT: begin
        if (root_last) state_next = vec ? ST_MUL : ST_SQUARE;
      end
      ST_MUL: state_next = ST_UPDATE;
      ST_UPDATE: state_next = vec ? ST_DONE : ST_MUL;
      ST_DONE: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    unique case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_DONE: load_out = !out_valid || out_ready;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      weight <= WEIGHT_RESET;
      cnt <= '0;
      vec <= 1'b0;
      out_valid <= 1'b0;
      acc_average <= '0;
      rate_average <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid) weight <= new_weight;
      if (in_fire) begin
        cnt <= '0;
        vec <= 1'b0;
      end else if (state == ST_SQUARE) begin
        cnt <= sq_last ? '0 : cnt + 1'b1;
      end else if (state == ST_ROOT) begin
        cnt <= root_last ? '0 : cnt + 1'b1;
        if (root_last) vec <= !vec;
      end else if (state == ST_UPDATE) begin
        vec <= !vec;
      end
      if (state == ST_UPDATE) begin
        if (vec) rate_average <= avg_clamped;
        else acc_average <= avg_clamped;
      end
      if (load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      acc_x_q <= acc_x;
      acc_y_q <= acc_y;
      acc_z_q <= acc_z;
      rate_x_q <= rate_x;
      rate_y_q <= rate_y;
      rate_z_q <= rate_z;
    end
    if (state == ST_SQUARE || state == ST_MUL) prod <= mul_out;
    if (state == ST_SQUARE) begin
      sum <= (cnt == '0) ? '0 : sum + prod[SQ_W-1:0];
      if (sq_last) begin
        rad <= RAD_W'(sum + prod[SQ_W-1:0]) << (2 * FRAC_BITS);
        rem <= '0;
        root <= '0;
      end
    end
    if (state == ST_ROOT) begin
      rad <= rad << 2;
      rem <= root_bit ? rem_sh - trial : rem_sh;
      root <= root_next;
      if (root_last) begin
        if (vec) rate_mag <= root_sat;
        else acc_mag <= root_sat;
      end
    end
    if (load_out) begin
      acc_magnitude <= acc_mag;
      rate_magnitude <= rate_mag;
      acc_smoothed <= acc_average;
      rate_smoothed <= rate_average;
    end
  end

`include "assert_macros.svh"

  `ASSERT_CLK(a_start_clean, in_fire |=> (state == ST_SQUARE && cnt == '0 && !vec))
  `ASSERT_CLK(a_root_count, (state == ST_ROOT) |-> (cnt < CNT_W'(ROOT_W)))
  `ASSERT_CLK(a_result_load, load_out |=> (out_valid && state == ST_IDLE))
  `ASSERT_CLK(a_weight_cap, weight_eff <= WEIGHT_ONE)
  `ASSERT_ANY(a_reset_clear, rst |=> (!out_valid && acc_average == '0 && state == ST_IDLE))

endmodule
`default_nettype wire

>>> tb/imu_magnitude_ema_check.sv
`default_nettype none
module imu_magnitude_ema_check #(
  parameter int FRAC_BITS = 4,
  parameter int SAMPLE_BITS = 16
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   cfg_valid,
  input  wire                                   cfg_ready,
  input  wire  [imu_mag_pkg::WEIGHT_W-1:0]      new_weight,
  input  wire                                   in_valid,
  input  wire                                   in_ready,
  input  wire  signed [imu_mag_pkg::AXIS_W-1:0] acc_x,
  input  wire  signed [imu_mag_pkg::AXIS_W-1:0] acc_y,
  input  wire  signed [imu_mag_pkg::AXIS_W-1:0] acc_z,
  input  wire  signed [imu_mag_pkg::AXIS_W-1:0] rate_x,
  input  wire  signed [imu_mag_pkg::AXIS_W-1:0] rate_y,
  input  wire  signed [imu_mag_pkg::AXIS_W-1:0] rate_z,
  input  wire                                   out_valid,
  input  wire                                   out_ready,
  input  wire  [imu_mag_pkg::MAG_W-1:0]         acc_magnitude,
  input  wire  [imu_mag_pkg::MAG_W-1:0]         rate_magnitude,
  input  wire  [imu_mag_pkg::MAG_W-1:0]         acc_smoothed,
  input  wire  [imu_mag_pkg::MAG_W-1:0]         rate_smoothed,
  output int                                    mismatches,
  output int                                    outstanding
);
  import imu_mag_pkg::*;

  typedef struct {
    logic [MAG_W-1:0] acc_mag;
    logic [MAG_W-1:0] rate_mag;
    logic [MAG_W-1:0] acc_avg;
    logic [MAG_W-1:0] rate_avg;
  } magnitude_word_t;

  magnitude_word_t expected_words[$];
  logic [WEIGHT_W-1:0] weight;
  logic [MAG_W-1:0] acc_avg;
  logic [MAG_W-1:0] rate_avg;

  // floor of the euclidean length with FRAC_BITS fraction bits, saturated
  function automatic logic [MAG_W-1:0] vector_length(
    input logic signed [AXIS_W-1:0] x,
    input logic signed [AXIS_W-1:0] y,
    input logic signed [AXIS_W-1:0] z
  );
    logic signed [AXIS_W-1:0] axis [3];
    logic signed [AXIS_W-1:0] narrow;
    longint part;
    longint unsigned rem;
    longint unsigned root;
    longint unsigned probe;
    axis = '{x, y, z};
    rem = 0;
    foreach (axis[i]) begin
      narrow = axis[i] <<< (AXIS_W - SAMPLE_BITS);
      narrow = narrow >>> (AXIS_W - SAMPLE_BITS);
      part = narrow;
      rem += part * part;
    end
    rem = rem << (2 * FRAC_BITS);
    root = 0;
    probe = 64'd1 << 62;
    while (probe > rem)
      probe >>= 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem -= root + probe;
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    if (root > MAG_MAX)
      return MAG_MAX;
    return root[MAG_W-1:0];
  endfunction

  // moving average step, rounded half up, weights past one act as one
  function automatic logic [MAG_W-1:0] smoothed_next(
    input logic [MAG_W-1:0] avg,
    input logic [MAG_W-1:0] mag
  );
    longint w;
    longint step;
    longint nxt;
    w = (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;
    step = (longint'(mag) - longint'(avg)) * w + longint'(ROUND_HALF);
    nxt = longint'(avg) + (step >>> WEIGHT_FRAC);
    if (nxt < 0)
      nxt = 0;
    if (nxt > longint'(MAG_MAX))
      nxt = longint'(MAG_MAX);
    return nxt[MAG_W-1:0];
  endfunction

  task automatic compare_field(
    input string field,
    input logic [MAG_W-1:0] want,
    input logic [MAG_W-1:0] got
  );
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    magnitude_word_t want;
    magnitude_word_t fresh;
    if (rst) begin
      weight = WEIGHT_RESET;
      acc_avg = '0;
      rate_avg = '0;
      expected_words.delete();
      mismatches = 0;
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready)
        weight = new_weight;
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("result word with no sample pending");
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          compare_field("acc_magnitude", want.acc_mag, acc_magnitude);
          compare_field("rate_magnitude", want.rate_mag, rate_magnitude);
          compare_field("acc_smoothed", want.acc_avg, acc_smoothed);
          compare_field("rate_smoothed", want.rate_avg, rate_smoothed);
        end
      end
      if (in_valid && in_ready) begin
        fresh.acc_mag = vector_length(acc_x, acc_y, acc_z);
        fresh.rate_mag = vector_length(rate_x, rate_y, rate_z);
        acc_avg = smoothed_next(acc_avg, fresh.acc_mag);
        rate_avg = smoothed_next(rate_avg, fresh.rate_mag);
        fresh.acc_avg = acc_avg;
        fresh.rate_avg = rate_avg;
        expected_words.push_back(fresh);
      end
      outstanding <= outstanding + int'(in_valid && in_ready) - int'(out_valid && out_ready);
    end
  end

endmodule
`default_nettype wire

>>> tb/tb_imu_magnitude_ema_filter.sv
`default_nettype none
module tb_imu_magnitude_ema_filter;
  import imu_mag_pkg::*;

  localparam int FRAC_BITS = 4;
  localparam int SAMPLE_BITS = 16;
  localparam int RESET_CYCLES = 6;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_WORDS = 54;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 64;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_PHASE = 4;

  // acc x, y, z then rate x, y, z
  localparam logic [5:0][15:0] DIRECTED_SAMPLES [15] = '{
    {16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
    {16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff},
    {16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000},
    {16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h0000},
    {16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h8000, 16'h8000},
    {16'h0001, 16'h0000, 16'h0000, 16'hffff, 16'h0000, 16'h0000},
    {16'hffff, 16'hffff, 16'hffff, 16'h0001, 16'h0001, 16'h0001},
    {16'h0000, 16'h0000, 16'h1000, 16'h0000, 16'h0000, 16'h0000},
    {16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000},
    {16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa},
    {16'h00ff, 16'hff00, 16'h0f0f, 16'hf0f0, 16'h3333, 16'hcccc},
    {16'h0003, 16'h0004, 16'h0000, 16'h0000, 16'h0005, 16'h000c},
    {16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
    {16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h7fff},
    {16'hfff0, 16'h0010, 16'h0000, 16'h0000, 16'h0001, 16'h0001}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [WEIGHT_W-1:0] new_weight = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [AXIS_W-1:0] acc_x = '0;
  logic signed [AXIS_W-1:0] acc_y = '0;
  logic signed [AXIS_W-1:0] acc_z = '0;
  logic signed [AXIS_W-1:0] rate_x = '0;
  logic signed [AXIS_W-1:0] rate_y = '0;
  logic signed [AXIS_W-1:0] rate_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [MAG_W-1:0] acc_magnitude;
  logic [MAG_W-1:0] rate_magnitude;
  logic [MAG_W-1:0] acc_smoothed;
  logic [MAG_W-1:0] rate_smoothed;

  int mismatches;
  int outstanding;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  bit hold_served = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  imu_magnitude_ema_filter #(
    .FRAC_BITS(FRAC_BITS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .new_weight(new_weight),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .acc_x(acc_x),
    .acc_y(acc_y),
    .acc_z(acc_z),
    .rate_x(rate_x),
    .rate_y(rate_y),
    .rate_z(rate_z),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .acc_magnitude(acc_magnitude),
    .rate_magnitude(rate_magnitude),
    .acc_smoothed(acc_smoothed),
    .rate_smoothed(rate_smoothed)
  );

  imu_magnitude_ema_check #(
    .FRAC_BITS(FRAC_BITS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) mag_check (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .new_weight(new_weight),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .acc_x(acc_x),
    .acc_y(acc_y),
    .acc_z(acc_z),
    .rate_x(rate_x),
    .rate_y(rate_y),
    .rate_z(rate_z),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .acc_magnitude(acc_magnitude),
    .rate_magnitude(rate_magnitude),
    .acc_smoothed(acc_smoothed),
    .rate_smoothed(rate_smoothed),
    .mismatches(mismatches),
    .outstanding(outstanding)
  );

  // result side, with one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_served) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_served <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("imu_magnitude_ema_filter test failed");
    $finish;
  end

  function automatic logic [5:0][15:0] random_sample();
    logic [5:0][15:0] s;
    int kind;
    kind = $urandom_range(0, 7);
    for (int i = 0; i < 6; i++) begin
      case (kind)
        0, 1, 2: s[i] = 16'($urandom());
        3: s[i] = 16'(int'($urandom_range(0, 128)) - 64);
        4: begin
          case ($urandom_range(0, 3))
            0: s[i] = 16'h8000;
            1: s[i] = 16'h7fff;
            2: s[i] = 16'h0000;
            default: s[i] = 16'hffff;
          endcase
        end
        default: begin
          // resting sensor: gravity on z, small noise elsewhere
          if (i == 3)
            s[i] = 16'(($urandom_range(0, 1) ? 4096 : -4096) + int'($urandom_range(0, 400)) - 200);
          else if (i > 3)
            s[i] = 16'(int'($urandom_range(0, 400)) - 200);
          else
            s[i] = 16'(int'($urandom_range(0, 4000)) - 2000);
        end
      endcase
    end
    return s;
  endfunction

  // valid is left high after the handshake; the next call or a drain decides
  task automatic send_sample(input logic [5:0][15:0] s);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {acc_x, acc_y, acc_z, rate_x, rate_y, rate_z} <= s;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_samples();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_weight(input logic [WEIGHT_W-1:0] w);
    cfg_valid <= 1'b1;
    new_weight <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [5:0][15:0] s;
    logic [5:0][15:0] prev;
    logic [WEIGHT_W-1:0] w;
    s = '0;
    prev = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed words at the reset weight
    foreach (DIRECTED_SAMPLES[i])
      send_sample(DIRECTED_SAMPLES[i]);
    drain_samples();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 63; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 63; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      case (p)
        0: w = '0;
        1: w = WEIGHT_ONE;
        2: w = '1;
        3: w = 11'd1;
        4: w = 11'd1025;
        5: w = 11'd512;
        default: w = 11'($urandom_range(0, 2047));
      endcase
      write_weight(w);
      if (p == HOLD_PHASE)
        hold_req = 1'b1;
      repeat (PHASE_WORDS) begin
        if ($urandom_range(0, 4) == 0)
          s = prev;
        else
          s = random_sample();
        send_sample(s);
        prev = s;
      end
      drain_samples();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("imu_magnitude_ema_filter test passed");
    else
      $display("imu_magnitude_ema_filter test failed");
    $finish;
  end

endmodule
`default_nettype wire

>>> files.f
+incdir+hdl
hdl/imu_mag_pkg.sv
hdl/imu_magnitude_ema_filter.sv
tb/imu_magnitude_ema_check.sv
tb/tb_imu_magnitude_ema_filter.sv
